/* rtl/wpp_pkg.sv */
// ----------------------------------------------------------------------------
// wpp_pkg
// Types and constants shared by the wav pcm stream parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  typedef enum logic [3:0] {
    PH_RIFF   = 4'd0,
    PH_RSIZE  = 4'd1,
    PH_WAVE   = 4'd2,
    PH_FMT    = 4'd3,
    PH_FSIZE  = 4'd4,
    PH_FIELDS = 4'd5,
    PH_SKIP   = 4'd6,
    PH_ID     = 4'd7,
    PH_LEN    = 4'd8,
    PH_DATA   = 4'd9,
    PH_DONE   = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_HEADER    = 3'd0,
    ERR_NOT_PCM   = 3'd1,
    ERR_CHUNK_ID  = 3'd2,
    ERR_SAMPLE_SZ = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       start_req;
    logic       last;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic               channel;
    logic signed [31:0] sample;
    err_e               error_code;
    logic [15:0]        channel_count;
    logic [31:0]        rate_of_samples;
    logic [31:0]        rate_of_bytes;
    logic [15:0]        block_bytes;
    logic [15:0]        sample_bits;
    logic [31:0]        payload_length;
  } res_t;

  // up to two result items per input byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // latin-1 letters: ascii letters, ordinal indicators, micro sign, upper block
  function automatic logic is_letter(input logic [7:0] c);
    logic res;
    res = 1'b0;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) res = 1'b1;
    if (c == 8'hAA || c == 8'hB5 || c == 8'hBA) res = 1'b1;
    if (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7) res = 1'b1;
    return res;
  endfunction

endpackage

/* rtl/wpp_parser.sv */
// ----------------------------------------------------------------------------
// wpp_parser
// Parser state and the per-byte step: header checks, fmt capture, chunk walk
// and sample extraction. Produces up to two result items per accepted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpp_parser import wpp_pkg::*; #(
  parameter int OUTPUT_CHANNELS = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  in_t   item_i,
  output push_t push_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [3:0]  bc_q, bc_d, cur_bc;
  logic [31:0] gather_q, gather_d, cur_gather;
  logic [31:0] fsize_q, fsize_d, cur_fsize;
  logic [15:0] chans_q, chans_d, cur_chans;
  logic [31:0] srate_q, srate_d, cur_srate;
  logic [31:0] brate_q, brate_d, cur_brate;
  logic [15:0] balign_q, balign_d, cur_balign;
  logic [15:0] bits_q, bits_d, cur_bits;
  logic [31:0] rem_q, rem_d, cur_rem;
  logic [15:0] off_q, off_d, cur_off;

  logic [7:0]  b;
  logic [4:0]  sh;
  logic [31:0] b_sh;
  logic        err_v;
  err_e        err_c;
  logic [1:0]  n;
  res_t        rl [2];
  res_t        rz;
  logic [31:0] g_new;
  logic [31:0] len_new;
  logic [31:0] skip_len;
  logic [12:0] bps_raw;
  logic [2:0]  bps;
  logic [15:0] frame;
  logic [15:0] o;
  logic [16:0] o1;
  logic        in_ch0, in_ch1;
  logic [1:0]  idx;
  logic [15:0] o_rel;
  logic [31:0] g_base;

  function automatic logic [31:0] sign_ext(input logic [31:0] v, input logic [2:0] w);
    logic [31:0] r;
    r = v;
    if (w == 3'd1) r = v - 32'd128;
    else if (w == 3'd2 && v[15]) r = v | 32'hFFFF_0000;
    else if (w == 3'd3 && v[23]) r = v | 32'hFF00_0000;
    return r;
  endfunction

  always_comb begin
    if (item_i.start_req) begin
      cur_phase  = PH_RIFF;
      cur_bc     = '0;
      cur_gather = '0;
      cur_fsize  = '0;
      cur_chans  = '0;
      cur_srate  = '0;
      cur_brate  = '0;
      cur_balign = '0;
      cur_bits   = '0;
      cur_rem    = '0;
      cur_off    = '0;
    end else begin
      cur_phase  = phase_q;
      cur_bc     = bc_q;
      cur_gather = gather_q;
      cur_fsize  = fsize_q;
      cur_chans  = chans_q;
      cur_srate  = srate_q;
      cur_brate  = brate_q;
      cur_balign = balign_q;
      cur_bits   = bits_q;
      cur_rem    = rem_q;
      cur_off    = off_q;
    end
  end

  always_comb begin
    phase_d  = cur_phase;
    bc_d     = cur_bc;
    gather_d = cur_gather;
    fsize_d  = cur_fsize;
    chans_d  = cur_chans;
    srate_d  = cur_srate;
    brate_d  = cur_brate;
    balign_d = cur_balign;
    bits_d   = cur_bits;
    rem_d    = cur_rem;
    off_d    = cur_off;

    b     = item_i.byte_req;
    sh    = {cur_bc[1:0], 3'b000};
    b_sh  = {24'd0, b} << sh;
    g_new = cur_gather | b_sh;
    err_v = 1'b0;
    err_c = ERR_HEADER;
    n     = 2'd0;
    rz    = '0;
    rl[0] = '0;
    rl[1] = '0;
    len_new  = cur_rem | b_sh;
    skip_len = cur_fsize - FMT_MIN_SIZE;

    bps_raw = cur_bits[15:3];
    bps     = (bps_raw >= 13'd1 && bps_raw <= 13'd4) ? bps_raw[2:0] : 3'd1;
    frame   = (cur_balign >= {13'd0, bps}) ? cur_balign : {13'd0, bps};
    o       = (cur_off >= frame) ? 16'd0 : cur_off;
    in_ch0  = o < {13'd0, bps};
    in_ch1  = !in_ch0 && (o < {12'd0, bps, 1'b0}) && (OUTPUT_CHANNELS > 1)
              && ({12'd0, bps, 1'b0} <= frame);
    o_rel   = in_ch0 ? o : o - {13'd0, bps};
    idx     = o_rel[1:0];
    g_base  = (idx == 2'd0) ? 32'd0 : cur_gather;
    o1      = {1'b0, o} + 17'd1;

    unique case (cur_phase)
      PH_RIFF, PH_WAVE, PH_FMT: begin
        gather_d = g_new;
        if (cur_bc[1:0] == 2'd3) begin
          if ((cur_phase == PH_RIFF && g_new != TAG_RIFF) ||
              (cur_phase == PH_WAVE && g_new != TAG_WAVE) ||
              (cur_phase == PH_FMT  && g_new != TAG_FMT)) begin
            err_v = 1'b1;
            err_c = ERR_HEADER;
          end else begin
            phase_d  = phase_e'(cur_phase + 4'd1);
            bc_d     = '0;
            gather_d = '0;
          end
        end else begin
          bc_d = cur_bc + 4'd1;
        end
      end
      PH_RSIZE: begin
        if (cur_bc[1:0] == 2'd3) begin
          phase_d  = PH_WAVE;
          bc_d     = '0;
          gather_d = '0;
        end else begin
          bc_d = cur_bc + 4'd1;
        end
      end
      PH_FSIZE: begin
        gather_d = g_new;
        if (cur_bc[1:0] == 2'd3) begin
          fsize_d = g_new;
          if (g_new < FMT_MIN_SIZE) begin
            err_v = 1'b1;
            err_c = ERR_HEADER;
          end else begin
            phase_d  = PH_FIELDS;
            bc_d     = '0;
            gather_d = '0;
            chans_d  = '0;
            srate_d  = '0;
            brate_d  = '0;
            balign_d = '0;
            bits_d   = '0;
          end
        end else begin
          bc_d = cur_bc + 4'd1;
        end
      end
      PH_FIELDS: begin
        // fmt field bytes in file order: format, channels, rates, align, bits
        if (cur_bc < 4'd2) begin
          gather_d = cur_gather | ({24'd0, b} << {cur_bc[0], 3'b000});
          if (cur_bc == 4'd1 && gather_d != 32'd1) begin
            err_v = 1'b1;
            err_c = ERR_NOT_PCM;
          end
        end else if (cur_bc < 4'd4) begin
          chans_d = cur_chans | ({8'd0, b} << {cur_bc[0], 3'b000});
        end else if (cur_bc < 4'd8) begin
          srate_d = cur_srate | ({24'd0, b} << {cur_bc[1:0], 3'b000});
        end else if (cur_bc < 4'd12) begin
          brate_d = cur_brate | ({24'd0, b} << {cur_bc[1:0], 3'b000});
        end else if (cur_bc < 4'd14) begin
          balign_d = cur_balign | ({8'd0, b} << {cur_bc[0], 3'b000});
        end else begin
          bits_d = cur_bits | ({8'd0, b} << {cur_bc[0], 3'b000});
        end
        if (!err_v) begin
          if (cur_bc == 4'd15) begin
            if (bits_d[15:3] < 13'd1 || bits_d[15:3] > 13'd4) begin
              err_v = 1'b1;
              err_c = ERR_SAMPLE_SZ;
            end else begin
              rem_d = skip_len;
              bc_d  = {3'd0, skip_len[0]};
              if (skip_len == 32'd0) begin
                phase_d  = PH_ID;
                gather_d = '0;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end else begin
            bc_d = cur_bc + 4'd1;
          end
        end
      end
      PH_SKIP: begin
        // bc holds the pad-byte flag here
        if (cur_rem != 32'd0) rem_d = cur_rem - 32'd1;
        else bc_d = '0;
        if (rem_d == 32'd0 && bc_d == 4'd0) begin
          phase_d  = PH_ID;
          bc_d     = '0;
          gather_d = '0;
        end
      end
      PH_ID: begin
        if (!is_letter(b)) begin
          err_v = 1'b1;
          err_c = ERR_CHUNK_ID;
        end else begin
          gather_d = g_new;
          if (cur_bc[1:0] == 2'd3) begin
            phase_d = PH_LEN;
            bc_d    = '0;
            rem_d   = '0;
          end else begin
            bc_d = cur_bc + 4'd1;
          end
        end
      end
      PH_LEN: begin
        rem_d = len_new;
        if (cur_bc[1:0] != 2'd3) begin
          bc_d = cur_bc + 4'd1;
        end else if (cur_gather == TAG_DATA) begin
          rl[0]                 = rz;
          rl[0].kind            = KIND_FORMAT;
          rl[0].channel_count   = cur_chans;
          rl[0].rate_of_samples = cur_srate;
          rl[0].rate_of_bytes   = cur_brate;
          rl[0].block_bytes     = cur_balign;
          rl[0].sample_bits     = cur_bits;
          rl[0].payload_length  = len_new;
          n        = 2'd1;
          phase_d  = PH_DATA;
          off_d    = '0;
          gather_d = '0;
          if (len_new == 32'd0) begin
            rl[1]      = rz;
            rl[1].kind = KIND_END;
            n          = 2'd2;
            phase_d    = PH_DONE;
          end
        end else begin
          bc_d = {3'd0, len_new[0]};
          if (len_new == 32'd0) begin
            phase_d  = PH_ID;
            gather_d = '0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_DATA: begin
        if (in_ch0 || in_ch1) begin
          gather_d = g_base | ({24'd0, b} << {idx, 3'b000});
          if ({1'b0, idx} == bps - 3'd1) begin
            rl[0]         = rz;
            rl[0].kind    = KIND_SAMPLE;
            rl[0].channel = in_ch1;
            rl[0].sample  = sign_ext(gather_d, bps);
            n             = 2'd1;
          end
        end
        off_d = (o1 >= {1'b0, frame}) ? 16'd0 : o1[15:0];
        rem_d = cur_rem - 32'd1;
        if (rem_d == 32'd0) begin
          rl[n[0]]      = rz;
          rl[n[0]].kind = KIND_END;
          n             = n + 2'd1;
          phase_d       = PH_DONE;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // errors from the phase step come only from phases that give no other item
    if (err_v) begin
      rl[0]            = rz;
      rl[0].kind       = KIND_ERROR;
      rl[0].error_code = err_c;
      n                = 2'd1;
      phase_d          = PH_DONE;
    end
    if (item_i.last && phase_d != PH_DONE) begin
      rl[n[0]]            = rz;
      rl[n[0]].kind       = KIND_ERROR;
      rl[n[0]].error_code = ERR_TRUNCATED;
      n                   = n + 2'd1;
      phase_d             = PH_DONE;
    end

    push_o.n  = accept_i ? n : 2'd0;
    push_o.r0 = rl[0];
    push_o.r1 = rl[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RIFF;
      bc_q     <= '0;
      gather_q <= '0;
      fsize_q  <= '0;
      chans_q  <= '0;
      srate_q  <= '0;
      brate_q  <= '0;
      balign_q <= '0;
      bits_q   <= '0;
      rem_q    <= '0;
      off_q    <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      bc_q     <= bc_d;
      gather_q <= gather_d;
      fsize_q  <= fsize_d;
      chans_q  <= chans_d;
      srate_q  <= srate_d;
      brate_q  <= brate_d;
      balign_q <= balign_d;
      bits_q   <= bits_d;
      rem_q    <= rem_d;
      off_q    <= off_d;
    end
  end

endmodule

/* rtl/wpp_res_fifo.sv */
// ----------------------------------------------------------------------------
// wpp_res_fifo
// Four-entry result queue: takes up to two items per cycle, gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpp_res_fifo import wpp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_item_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic [PtrW-1:0] wr_next;
  logic            pop;

  assign wr_next     = wr_q + PtrW'(1);
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_q];
  assign room_o      = cnt_q <= CntW'(Depth - 2);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (push_i.n != 2'd0 && PtrW'(i) == wr_q) begin
        mem_q[i] <= push_i.r0;
      end else if (push_i.n == 2'd2 && PtrW'(i) == wr_next) begin
        mem_q[i] <= push_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.n);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(push_i.n) - CntW'(pop);
    end
  end

endmodule

/* rtl/wav_pcm_stream_parser.sv */
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// Byte-wide RIFF/WAVE PCM parser: header checks, format report, samples.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one file byte per item, with start_req on the first byte of a
//                 file and last on its final byte
//   out channel : result items (sample, format report, error, end of data)
//   Each accepted byte is parsed in the cycle it is taken and its results
//   (zero, one or two items) are written to a four-entry result queue.
//   Throughput is one byte per cycle while the queue has room for two items;
//   in_ready_o drops when the queue holds more than two items, which happens
//   only when the receiver stalls.
//   Reset empties the queue and puts the parser at the RIFF tag; start_req
//   does the same for the parser alone. After an error or the end of data
//   the parser drops bytes until the next start_req.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wav_pcm_stream_parser import wpp_pkg::*; #(
  parameter int OUTPUT_CHANNELS = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_item_o
);

  push_t push;
  logic  room;
  logic  accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  wpp_parser #(
    .OUTPUT_CHANNELS (OUTPUT_CHANNELS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push)
  );

  wpp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
